/* hdl/sbit_pkg.sv */
// shared types, widths and pipeline helpers for the segment/box intersection test
`default_nettype none

package sbit_pkg;

    // coordinate, grown-box, plane-offset and divisor widths
    localparam int CW = 32;
    localparam int GW = 33;
    localparam int NW = 34;
    localparam int DW = 33;
    localparam int TW = 16;

    // one of the two other axes seen from a face
    typedef struct packed {
        logic signed [CW-1:0] s;
        logic                 vneg;
        logic [DW-1:0]        av;
        logic signed [GW-1:0] lo;
        logic signed [GW-1:0] hi;
    } t_side;

    // everything a face unit needs for one item
    typedef struct packed {
        logic signed [GW-1:0] pl;
        logic signed [CW-1:0] s_a;
        logic signed [GW-1:0] v_a;
        t_side [1:0]          side;
    } t_face_geom;

    // integer-part bound on the face parameter
    function automatic int f_t_limit(int frac);
        return 2 + (65535 >> frac);
    endfunction

    // integer bits of the quotient
    function automatic int f_quot_bits(int frac);
        return $clog2(f_t_limit(frac));
    endfunction

    // register stages through one face unit
    function automatic int f_face_lat(int frac);
        return f_quot_bits(frac) + frac + 5;
    endfunction

endpackage

`default_nettype wire

/* hdl/sbit_face.sv */
// one face test: pipelined parameter divider, offset multiply and bound checks
`default_nettype none

module sbit_face #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_ce,
    input  wire logic [15:0]           i_tol,
    input  wire sbit_pkg::t_face_geom  i_geom,
    output logic                       o_hit
);

    localparam int QB   = sbit_pkg::f_quot_bits(FRAC_BITS);
    localparam int QW   = QB + FRAC_BITS;
    localparam int TLIM = sbit_pkg::f_t_limit(FRAC_BITS);
    localparam int DW   = sbit_pkg::DW;
    localparam int NW   = sbit_pkg::NW;
    localparam int LW   = DW + QB + 1;
    localparam int CMW  = QW + 18;
    localparam int PRW  = QW + 16;
    localparam int FW   = QW + 33;
    localparam int MW   = QB + 33;
    localparam int PW   = QB + 36;

    typedef struct packed {
        logic                  live;
        logic                  neg;
        sbit_pkg::t_side [1:0] side;
    } t_div_ctx;

    // stage 1: plane offset, sign folding, axis use
    logic signed [NW-1:0] w_num;
    logic [NW-1:0]        w_an;
    logic [DW-1:0]        w_ud;
    logic                 w_neg;
    logic                 w_use;
    logic [NW-1:0]        r1_an;
    logic [DW-1:0]        r1_ud;
    logic                 r1_neg;
    logic                 r1_use;
    sbit_pkg::t_side [1:0] r1_side;

    always_comb begin
        w_num = $signed({i_geom.pl[32], i_geom.pl}) - $signed({{2{i_geom.s_a[31]}}, i_geom.s_a});
        w_an  = w_num[NW-1] ? NW'(-w_num) : NW'(w_num);
        w_ud  = i_geom.v_a[32] ? DW'(-i_geom.v_a) : DW'(i_geom.v_a);
        w_neg = (w_num[NW-1] ^ i_geom.v_a[32]) && (w_num != '0);
        w_use = w_ud > {{(DW-16){1'b0}}, i_tol};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_an   <= w_an;
            r1_ud   <= w_ud;
            r1_neg  <= w_neg;
            r1_use  <= w_use;
            r1_side <= i_geom.side;
        end
    end

    // stage 2: far parameter check and divider set-up
    logic [LW-1:0] w_lim;
    logic          w_over;
    logic [DW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_ud  [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    t_div_ctx      r_ctx [QW+1];

    always_comb begin
        w_lim  = LW'(r1_ud) * LW'(TLIM);
        w_over = LW'(r1_an) >= w_lim;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]      <= DW'(r1_an >> QB);
            r_ud[0]       <= r1_ud;
            r_low[0]      <= {r1_an[QB-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]        <= '0;
            r_ctx[0].live <= r1_use && !w_over;
            r_ctx[0].neg  <= r1_neg;
            r_ctx[0].side <= r1_side;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0] w_t;
        logic        w_ge;

        always_comb begin
            w_t  = {r_rem[k], r_low[k][QW-1]};
            w_ge = w_t >= {1'b0, r_ud[k]};
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k+1] <= w_ge ? DW'(w_t - {1'b0, r_ud[k]}) : DW'(w_t);
                r_ud[k+1]  <= r_ud[k];
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][QW-2:0], w_ge};
                r_ctx[k+1] <= r_ctx[k];
            end
        end
    end

    // parameter range check and split offset products
    logic [CMW-1:0] w_mt;
    logic [CMW-1:0] w_tol;
    logic           w_t_ok;
    logic           r_m_live;
    logic           r_m_neg;
    logic [PRW-1:0] r_m_p0 [2];
    logic [PRW-1:0] r_m_p1 [2];
    sbit_pkg::t_side [1:0] r_m_side;

    always_comb begin
        w_mt  = CMW'(r_q[QW]);
        w_tol = CMW'(i_tol);
        if (r_ctx[QW].neg) begin
            w_t_ok = w_mt < w_tol;
        end else begin
            w_t_ok = ((w_mt != '0) || (w_tol != '0)) &&
                     (w_mt < ((CMW'(1) << FRAC_BITS) + w_tol));
        end
    end

    for (genvar i = 0; i < 2; i++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_m_p0[i] <= PRW'(r_q[QW]) * PRW'(r_ctx[QW].side[i].av[15:0]);
                r_m_p1[i] <= PRW'(r_q[QW]) * PRW'(r_ctx[QW].side[i].av[DW-1:16]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m_live <= r_ctx[QW].live && w_t_ok;
            r_m_neg  <= r_ctx[QW].neg;
            r_m_side <= r_ctx[QW].side;
        end
    end

    // offset magnitude, truncated to coordinate lsbs
    logic [MW-1:0] r_s_dm [2];
    logic          r_s_live;
    logic          r_s_neg;
    sbit_pkg::t_side [1:0] r_s_side;

    for (genvar i = 0; i < 2; i++) begin : g_sum
        logic [FW-1:0] w_full;

        always_comb begin
            w_full = (FW'(r_m_p1[i]) << 16) + FW'(r_m_p0[i]);
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_s_dm[i] <= w_full[FW-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s_live <= r_m_live;
            r_s_neg  <= r_m_neg;
            r_s_side <= r_m_side;
        end
    end

    // intersection point against the widened box
    logic [1:0] w_in;
    logic       r_hit;

    for (genvar i = 0; i < 2; i++) begin : g_pt
        logic signed [PW-1:0] w_pt;
        logic signed [PW-1:0] w_dlo;
        logic signed [PW-1:0] w_dhi;
        logic signed [PW-1:0] w_dm;
        logic signed [PW-1:0] w_tl;

        always_comb begin
            w_dm = $signed({{(PW-MW){1'b0}}, r_s_dm[i]});
            w_tl = $signed({{(PW-16){1'b0}}, i_tol});
            if (r_s_neg ^ r_s_side[i].vneg) begin
                w_pt = $signed({{(PW-32){r_s_side[i].s[31]}}, r_s_side[i].s}) - w_dm;
            end else begin
                w_pt = $signed({{(PW-32){r_s_side[i].s[31]}}, r_s_side[i].s}) + w_dm;
            end
            w_dlo = w_pt - $signed({{(PW-33){r_s_side[i].lo[32]}}, r_s_side[i].lo}) + w_tl;
            w_dhi = w_pt - $signed({{(PW-33){r_s_side[i].hi[32]}}, r_s_side[i].hi}) - w_tl;
            w_in[i] = !w_dlo[PW-1] && (w_dlo != '0) && w_dhi[PW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_hit <= r_s_live && (&w_in);
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

/* hdl/segment_box_intersection_test_top.sv */
// segment versus grown axis-aligned box test, pipelined over six face units
//
// usage: one box and one segment per input transfer on i_valid/o_stall,
// all coordinates signed fixed point with COORD_FRAC_BITS fraction bits.
// one result transfer (o_hit) per input on o_valid/i_stall, in order.
// the tolerance register is written through i_cfg_we/i_cfg_data; the user must
// write it only while the pipeline is empty, which the block does not enforce;
// it resets to one lsb. each item passes the input stage registers, the face
// unit register stages and the output register; the six face units each run a
// restoring divider with one quotient bit per stage, which sets the depth.
// throughput: one transfer per cycle while o_stall is low.
// a stalled result holds o_hit; the whole pipeline freezes with it and
// o_stall is raised, so nothing is lost or repeated.
// reset clears all valid bits but not the registered o_hit; the block takes a
// transfer in the first cycle after reset.
`default_nettype none

module segment_box_intersection_test_top #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_box_min_x,
    input  wire logic signed [31:0] i_box_min_y,
    input  wire logic signed [31:0] i_box_min_z,
    input  wire logic signed [31:0] i_box_max_x,
    input  wire logic signed [31:0] i_box_max_y,
    input  wire logic signed [31:0] i_box_max_z,
    input  wire logic signed [31:0] i_start_x,
    input  wire logic signed [31:0] i_start_y,
    input  wire logic signed [31:0] i_start_z,
    input  wire logic signed [31:0] i_end_x,
    input  wire logic signed [31:0] i_end_y,
    input  wire logic signed [31:0] i_end_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit
);

    localparam int FL = sbit_pkg::f_face_lat(COORD_FRAC_BITS);

    // pipeline advance
    logic w_ce;
    logic r_out_valid;
    logic r_out_hit;

    assign w_ce    = !(r_out_valid && i_stall);
    assign o_stall = !w_ce;

    // tolerance register
    logic [15:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd1;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // grown box, direction and start-point inside test
    logic signed [31:0] w_min [3];
    logic signed [31:0] w_max [3];
    logic signed [31:0] w_s   [3];
    logic signed [31:0] w_e   [3];
    logic signed [32:0] w_lo  [3];
    logic signed [32:0] w_hi  [3];
    logic signed [32:0] w_v   [3];
    sbit_pkg::t_side    w_side [3];
    logic [2:0]         w_ax_in;

    always_comb begin
        w_min[0] = i_box_min_x;
        w_min[1] = i_box_min_y;
        w_min[2] = i_box_min_z;
        w_max[0] = i_box_max_x;
        w_max[1] = i_box_max_y;
        w_max[2] = i_box_max_z;
        w_s[0]   = i_start_x;
        w_s[1]   = i_start_y;
        w_s[2]   = i_start_z;
        w_e[0]   = i_end_x;
        w_e[1]   = i_end_y;
        w_e[2]   = i_end_z;
        for (int a = 0; a < 3; a++) begin
            w_lo[a] = $signed({w_min[a][31], w_min[a]}) - $signed({17'd0, r_tol});
            w_hi[a] = $signed({w_max[a][31], w_max[a]}) + $signed({17'd0, r_tol});
            w_v[a]  = $signed({w_e[a][31], w_e[a]}) - $signed({w_s[a][31], w_s[a]});
            w_side[a].s    = w_s[a];
            w_side[a].vneg = w_v[a][32];
            w_side[a].av   = w_v[a][32] ? 33'(-w_v[a]) : 33'(w_v[a]);
            w_side[a].lo   = w_lo[a];
            w_side[a].hi   = w_hi[a];
            w_ax_in[a] = ($signed({w_s[a][31], w_s[a]}) >= w_lo[a]) &&
                         ($signed({w_s[a][31], w_s[a]}) <= w_hi[a]);
        end
    end

    // input stage registers
    sbit_pkg::t_face_geom r_geom [6];
    logic                 r_vld1;
    logic                 r_ins1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (w_ce) begin
            r_vld1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ins1 <= &w_ax_in;
        end
    end

    // six face units, lower and upper plane per axis
    logic [5:0] w_fhit;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int O1 = (a + 1) % 3;
        localparam int O2 = (a + 2) % 3;
        for (genvar p = 0; p < 2; p++) begin : g_plane
            sbit_pkg::t_face_geom w_geom;

            always_comb begin
                w_geom.pl      = (p == 0) ? w_lo[a] : w_hi[a];
                w_geom.s_a     = w_s[a];
                w_geom.v_a     = w_v[a];
                w_geom.side[0] = w_side[O1];
                w_geom.side[1] = w_side[O2];
            end

            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_geom[2*a+p] <= w_geom;
                end
            end

            sbit_face #(
                .FRAC_BITS (COORD_FRAC_BITS)
            ) u_face (
                .i_clk  (i_clk),
                .i_ce   (w_ce),
                .i_tol  (r_tol),
                .i_geom (r_geom[2*a+p]),
                .o_hit  (w_fhit[2*a+p])
            );
        end
    end

    // valid and inside flag travel alongside the face units
    logic [FL-1:0] r_vld_line;
    logic [FL-1:0] r_ins_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_line <= '0;
        end else if (w_ce) begin
            r_vld_line <= {r_vld_line[FL-2:0], r_vld1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ins_line <= {r_ins_line[FL-2:0], r_ins1};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= r_vld_line[FL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_hit <= (|w_fhit) || r_ins_line[FL-1];
        end
    end

    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;

    // checks
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result waiting");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_freeze_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> ($stable(r_vld_line) && $stable(r_vld1)))
        else $error("pipeline valid bits moved during a stall");

    a_line_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ce && r_vld_line[FL-1]) |=> o_valid)
        else $error("item lost between pipeline and output register");

endmodule

`default_nettype wire

/* test/segment_box_intersection_test_top_test.sv */
// self-checking testbench for the segment versus grown box intersection block
`default_nettype none

module segment_box_intersection_test_top_test;

    localparam int FRAC      = 16;
    localparam int FAR_LIMIT = 2 + (65535 >> FRAC);
    localparam int LATENCY   = 23;
    localparam int N_RANDOM  = 1400;

    typedef struct {
        logic signed [31:0] bmin [3];
        logic signed [31:0] bmax [3];
        logic signed [31:0] p0 [3];
        logic signed [31:0] p1 [3];
    } t_query;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] bmin_x = '0, bmin_y = '0, bmin_z = '0;
    logic signed [31:0] bmax_x = '0, bmax_y = '0, bmax_z = '0;
    logic signed [31:0] p0_x = '0, p0_y = '0, p0_z = '0;
    logic signed [31:0] p1_x = '0, p1_y = '0, p1_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit;

    t_query pending_q [$];
    bit     expected_hits [$];
    logic [15:0] slack = 16'd1;
    int errors = 0;
    bit hold_req = 1'b0;
    bit long_hold = 1'b0;

    segment_box_intersection_test_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_box_min_x(bmin_x), .i_box_min_y(bmin_y), .i_box_min_z(bmin_z),
        .i_box_max_x(bmax_x), .i_box_max_y(bmax_y), .i_box_max_z(bmax_z),
        .i_start_x(p0_x), .i_start_y(p0_y), .i_start_z(p0_z),
        .i_end_x(p1_x), .i_end_y(p1_y), .i_end_z(p1_z),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // face test along one axis at one plane
    function automatic bit face_touched(int a, longint pl, longint s[3], longint v[3],
                                        longint lo[3], longint hi[3], longint tol);
        longint num, den, t, pt;
        longint unsigned an, ud, q, fr, mt, av, dm;
        bit neg;
        num = pl - s[a];
        den = v[a];
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        neg = num < 0;
        an = neg ? -num : num;
        ud = den;
        q = an / ud;
        if (q >= FAR_LIMIT) return 1'b0;
        fr = ((an % ud) << FRAC) / ud;
        mt = (q << FRAC) + fr;
        t = neg ? -longint'(mt) : longint'(mt);
        if (!(t > -tol && t < (longint'(1) << FRAC) + tol)) return 1'b0;
        for (int o = 0; o < 3; o++) begin
            if (o == a) continue;
            av = v[o] < 0 ? -v[o] : v[o];
            dm = q * av + ((fr * av) >> FRAC);
            pt = (neg != (v[o] < 0)) ? s[o] - longint'(dm) : s[o] + longint'(dm);
            if (!(pt - lo[o] > -tol && pt - hi[o] < tol)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected hit flag for one query
    function automatic bit segment_hits_box(t_query qy, logic [15:0] tsl);
        longint lo[3], hi[3], s[3], v[3];
        longint tol;
        bit hit;
        tol = tsl;
        hit = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = longint'(qy.bmin[a]) - tol;
            hi[a] = longint'(qy.bmax[a]) + tol;
            s[a] = qy.p0[a];
            v[a] = longint'(qy.p1[a]) - s[a];
        end
        for (int a = 0; a < 3 && !hit; a++) begin
            if ((v[a] < 0 ? -v[a] : v[a]) > tol) begin
                if (face_touched(a, lo[a], s, v, lo, hi, tol) ||
                    face_touched(a, hi[a], s, v, lo, hi, tol))
                    hit = 1'b1;
            end
        end
        if (!hit) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++)
                if (s[a] < lo[a] || s[a] > hi[a]) hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
        endcase
    endfunction

    // random box with a segment near it, or with all coordinates random
    function automatic t_query random_query();
        t_query qy;
        logic signed [31:0] c, w;
        bit wild;
        wild = $urandom_range(0, 9) == 0;
        for (int a = 0; a < 3; a++) begin
            if (wild) begin
                qy.bmin[a] = rand_coord();
                qy.bmax[a] = rand_coord();
                qy.p0[a] = rand_coord();
                qy.p1[a] = rand_coord();
            end else begin
                c = $signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC);
                w = $urandom_range(0, 3 << FRAC);
                qy.bmin[a] = c - w;
                qy.bmax[a] = ($urandom_range(0, 19) == 0) ? c - w - 5 : c + w;
                qy.p0[a] = c + $signed($urandom_range(0, 12 << FRAC)) - (6 << FRAC);
                qy.p1[a] = ($urandom_range(0, 7) == 0) ?
                           qy.p0[a] + $signed($urandom_range(0, 4)) - 2 :
                           c + $signed($urandom_range(0, 12 << FRAC)) - (6 << FRAC);
            end
        end
        return qy;
    endfunction

    function automatic t_query flat_query(logic signed [31:0] b0, logic signed [31:0] b1,
                                          logic signed [31:0] s, logic signed [31:0] e);
        t_query qy;
        for (int a = 0; a < 3; a++) begin
            qy.bmin[a] = b0;
            qy.bmax[a] = b1;
            qy.p0[a] = s;
            qy.p1[a] = e;
        end
        return qy;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || i_valid || expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_slack(logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        slack = val;
        @(posedge i_clk);
    endtask

    // driver: present the next queued query after a random gap
    int gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            end
            if (!i_valid || !o_stall) begin
                if (gap > 0) begin
                    gap--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    t_query qy;
                    qy = pending_q.pop_front();
                    expected_hits.push_back(segment_hits_box(qy, slack));
                    bmin_x <= qy.bmin[0]; bmin_y <= qy.bmin[1]; bmin_z <= qy.bmin[2];
                    bmax_x <= qy.bmax[0]; bmax_y <= qy.bmax[1]; bmax_z <= qy.bmax[2];
                    p0_x <= qy.p0[0]; p0_y <= qy.p0[1]; p0_z <= qy.p0[2];
                    p1_x <= qy.p1[0]; p1_y <= qy.p1[1]; p1_z <= qy.p1[2];
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted in cycles
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (200) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // monitor: compare each result transfer and draw the receiver stall
    int rx_wait = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    bit want;
                    want = expected_hits.pop_front();
                    if (o_hit !== want)
                        report_mismatch($sformatf("hit %b, expected %b", o_hit, want));
                end
                rx_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            end
            if (long_hold) begin
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // stimulus
    logic [15:0] slack_set [4] = '{16'd0, 16'd65535, 16'd300, 16'd1};
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, inside point, degenerate, far and inverted
        pending_q.push_back(flat_query(-(1 << FRAC), 1 << FRAC, 0, 0));
        pending_q.push_back(flat_query(-(1 << FRAC), 1 << FRAC, 5 << FRAC, -(5 << FRAC)));
        pending_q.push_back(flat_query(-(1 << FRAC), 1 << FRAC, 5 << FRAC, 4 << FRAC));
        pending_q.push_back(flat_query(32'sh80000000, 32'sh7fffffff,
                                       32'sh80000000, 32'sh7fffffff));
        pending_q.push_back(flat_query(32'sh7fffffff, 32'sh80000000, 0, 1));
        pending_q.push_back(flat_query(32'shffffffff, 32'sh0, 32'sh55555555, 32'shaaaaaaaa));
        pending_q.push_back(flat_query(0, 0, 1, 1));
        pending_q.push_back(flat_query(0, 1, 32'sh7fff0000, 32'sh7ffeffff));
        pending_q.push_back(flat_query(1 << FRAC, 2 << FRAC, 0, 1 << FRAC));
        pending_q.push_back(flat_query(1 << FRAC, 2 << FRAC, 0, 3 << FRAC));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_slack(slack_set[ph]);
            for (int n = 0; n < N_RANDOM / 4; n++)
                pending_q.push_back(random_query());
            if (ph == 1) hold_req = 1'b1;
            wait_drained();
        end

        if (errors == 0) begin
            $display("segment_box_intersection_test_top regression: pass");
        end else begin
            $display("segment_box_intersection_test_top regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("segment_box_intersection_test_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* segment_box_intersection_test_top.f */
hdl/sbit_pkg.sv
hdl/sbit_face.sv
hdl/segment_box_intersection_test_top.sv
test/segment_box_intersection_test_top_test.sv
